// ===== sv/lpht_pkg.sv =====
// shared types, widths, codes and the remainder step for the linear probe hash table
// no dependencies; imported by linear_probe_hash_table

package lpht_pkg;

   localparam int MAX_SLOTS_DEF = 128;

   localparam int KIND_W   = 2;
   localparam int KEY_W    = 31;
   localparam int STATUS_W = 2;
   localparam int SLOT_W   = 7;
   localparam int SIZE_W   = 8;
   localparam int ENTRY_W  = KEY_W + 1;

   localparam int CSR_DATA_W = 32;
   localparam int CSR_ADDR_W = 3;

   localparam int MOD_STEP   = 8;
   localparam int MOD_WORD_W = 32;
   localparam int MOD_ITERS  = MOD_WORD_W / MOD_STEP;
   localparam int MOD_CNT_W  = $clog2(MOD_ITERS);

   typedef logic [KIND_W-1:0]   kind_type;
   typedef logic [STATUS_W-1:0] status_type;
   typedef logic [SIZE_W-1:0]   size_type;

   localparam kind_type KIND_INSERT = 2'd0;
   localparam kind_type KIND_SEARCH = 2'd1;
   localparam kind_type KIND_REMOVE = 2'd2;

   localparam status_type STAT_OK     = 2'd0;
   localparam status_type STAT_ABSENT = 2'd1;
   localparam status_type STAT_FULL   = 2'd2;

   localparam size_type   SIZE_RESET     = 8'd128;
   localparam logic [0:0] REG_TABLE_SIZE = 1'b0;

   // restoring remainder over MOD_STEP dividend bits, msb first
   function automatic size_type mod_step(input size_type rem,
                                         input logic [MOD_STEP-1:0] bits,
                                         input size_type n);
      logic [SIZE_W:0] t;
      size_type r;
      r = rem;
      for (int i = MOD_STEP - 1; i >= 0; i--) begin
         t = {r, bits[i]};
         if (t >= {1'b0, n}) begin
            t = t - {1'b0, n};
         end
         r = t[SIZE_W-1:0];
      end
      return r;
   endfunction

endpackage

// ===== sv/lpht_ram.sv =====
// generic single-write, single-read synchronous ram with registered read data
// no dependencies

module lpht_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 128
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      rdata_ff <= mem_ff[raddr];
   end

   assign rdata = rdata_ff;

endmodule

// ===== sv/linear_probe_hash_table.sv =====
// Open-addressing hash table with linear probing over one ram of {valid, key} entries.
// Every request (insert, search, remove) gives exactly one response. After reset the
// block runs a clearing pass over all MAX_SLOTS entries with req_stall high. An operation is
// accepted, computes the home slot (key mod size, 8 bits a cycle), reads the ram, probes one
// slot per cycle and hands over the result, waiting while a pending response is stalled.
// A remove then walks the cluster behind the freed slot, reading, rehashing and testing each
// entry, and moves each entry it shifts back into the hole before clearing its old slot.
// Depends on lpht_pkg and lpht_ram.

module linear_probe_hash_table #(
   parameter int MAX_SLOTS = lpht_pkg::MAX_SLOTS_DEF
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_stall,
   input  logic [lpht_pkg::KIND_W-1:0]         req_kind,
   input  logic [lpht_pkg::KEY_W-1:0]          req_key,
   output logic                                rsp_valid,
   input  logic                                rsp_stall,
   output logic [lpht_pkg::STATUS_W-1:0]       rsp_status,
   output logic [lpht_pkg::SLOT_W-1:0]         rsp_slot,
   input  logic                                csr_psel,
   input  logic                                csr_penable,
   input  logic                                csr_pwrite,
   input  logic [lpht_pkg::CSR_ADDR_W-1:0]     csr_paddr,
   input  logic [lpht_pkg::CSR_DATA_W-1:0]     csr_pwdata,
   output logic [lpht_pkg::CSR_DATA_W-1:0]     csr_prdata,
   output logic                                csr_pready
);

   import lpht_pkg::*;

   localparam int IDX_W = $clog2(MAX_SLOTS);
   localparam int CMP_W = (IDX_W > SIZE_W) ? IDX_W + 1 : SIZE_W + 1;

   localparam logic [3:0] S_CLEAR    = 4'd0;
   localparam logic [3:0] S_IDLE     = 4'd1;
   localparam logic [3:0] S_HASH     = 4'd2;
   localparam logic [3:0] S_PROBE_RD = 4'd3;
   localparam logic [3:0] S_CHECK    = 4'd4;
   localparam logic [3:0] S_SH_READ  = 4'd5;
   localparam logic [3:0] S_SH_DATA  = 4'd6;
   localparam logic [3:0] S_SH_HASH  = 4'd7;
   localparam logic [3:0] S_SH_TEST  = 4'd8;
   localparam logic [3:0] S_MOVE_A   = 4'd9;
   localparam logic [3:0] S_MOVE_B   = 4'd10;
   localparam logic [3:0] S_FINISH   = 4'd11;

   logic [3:0]            state_ff, state_in;
   logic [IDX_W-1:0]      clr_ff, clr_in;
   kind_type              kind_ff, kind_in;
   logic [KEY_W-1:0]      key_ff, key_in;
   logic [KEY_W-1:0]      jkey_ff, jkey_in;
   size_type              n_ff, n_in;
   size_type              table_size_ff, table_size_in;
   logic [MOD_WORD_W-1:0] mod_word_ff, mod_word_in;
   size_type              mod_rem_ff, mod_rem_in;
   logic [MOD_CNT_W-1:0]  mod_cnt_ff, mod_cnt_in;
   logic [IDX_W-1:0]      s_ff, s_in;
   logic [IDX_W-1:0]      hole_ff, hole_in;
   logic [IDX_W-1:0]      j_ff, j_in;
   size_type              probe_ff, probe_in;
   status_type            res_status_ff, res_status_in;
   logic [IDX_W-1:0]      res_slot_ff, res_slot_in;
   logic                  rsp_valid_ff, rsp_valid_in;
   status_type            rsp_status_ff, rsp_status_in;
   logic [SLOT_W-1:0]     rsp_slot_ff, rsp_slot_in;

   logic                  ram_we;
   logic [IDX_W-1:0]      ram_waddr;
   logic [ENTRY_W-1:0]    ram_wdata;
   logic [IDX_W-1:0]      ram_raddr;
   logic [ENTRY_W-1:0]    ram_rdata;

   size_type              n_cur;
   size_type              step_rem;
   logic [IDX_W-1:0]      nxt_s;
   logic [IDX_W-1:0]      nxt_j;
   logic                  e_valid;
   logic [KEY_W-1:0]      e_key;
   logic                  last_probe;
   logic                  movable;
   logic [CMP_W-1:0]      home_c, hole_c, j_c;
   logic                  csr_write;

   function automatic logic [IDX_W-1:0] next_idx(input logic [IDX_W-1:0] s,
                                                 input size_type n);
      logic [CMP_W-1:0] inc;
      inc = CMP_W'(s) + CMP_W'(1);
      return (inc >= CMP_W'(n)) ? '0 : IDX_W'(inc);
   endfunction

   lpht_ram #(
      .WIDTH (ENTRY_W),
      .DEPTH (MAX_SLOTS)
   ) u_ram (
      .clock (clock),
      .we    (ram_we),
      .waddr (ram_waddr),
      .wdata (ram_wdata),
      .raddr (ram_raddr),
      .rdata (ram_rdata)
   );

   // csr port
   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel & csr_penable & csr_pwrite;
   assign csr_prdata = (csr_paddr[2] == REG_TABLE_SIZE) ? CSR_DATA_W'(table_size_ff) : '0;

   always_comb begin
      table_size_in = table_size_ff;
      if (csr_write && csr_paddr[2] == REG_TABLE_SIZE) begin
         table_size_in = csr_pwdata[SIZE_W-1:0];
      end
   end

   // active size clamped to 1..MAX_SLOTS
   always_comb begin
      if (table_size_ff == '0) begin
         n_cur = SIZE_W'(1);
      end else if (32'(table_size_ff) > MAX_SLOTS) begin
         n_cur = SIZE_W'(MAX_SLOTS);
      end else begin
         n_cur = table_size_ff;
      end
   end

   assign step_rem   = mod_step(mod_rem_ff, mod_word_ff[MOD_WORD_W-1 -: MOD_STEP], n_ff);
   assign nxt_s      = next_idx(s_ff, n_ff);
   assign nxt_j      = next_idx(j_ff, n_ff);
   assign e_valid    = ram_rdata[KEY_W];
   assign e_key      = ram_rdata[KEY_W-1:0];
   assign last_probe = ({1'b0, probe_ff} + (SIZE_W + 1)'(1)) == {1'b0, n_ff};

   assign home_c = CMP_W'(mod_rem_ff);
   assign hole_c = CMP_W'(hole_ff);
   assign j_c    = CMP_W'(j_ff);
   assign movable = (j_c > hole_c) ? ((home_c <= hole_c) || (home_c > j_c))
                                   : ((home_c <= hole_c) && (home_c > j_c));

   assign req_stall = (state_ff != S_IDLE);

   always_comb begin
      state_in      = state_ff;
      clr_in        = clr_ff;
      kind_in       = kind_ff;
      key_in        = key_ff;
      jkey_in       = jkey_ff;
      n_in          = n_ff;
      mod_word_in   = mod_word_ff;
      mod_rem_in    = mod_rem_ff;
      mod_cnt_in    = mod_cnt_ff;
      s_in          = s_ff;
      hole_in       = hole_ff;
      j_in          = j_ff;
      probe_in      = probe_ff;
      res_status_in = res_status_ff;
      res_slot_in   = res_slot_ff;
      rsp_valid_in  = rsp_valid_ff & rsp_stall;
      rsp_status_in = rsp_status_ff;
      rsp_slot_in   = rsp_slot_ff;
      ram_we        = 1'b0;
      ram_waddr     = s_ff;
      ram_wdata     = {1'b0, key_ff};
      ram_raddr     = s_ff;

      unique case (state_ff)
         S_CLEAR: begin
            ram_we    = 1'b1;
            ram_waddr = clr_ff;
            ram_wdata = '0;
            clr_in    = clr_ff + IDX_W'(1);
            if (clr_ff == IDX_W'(MAX_SLOTS - 1)) begin
               state_in = S_IDLE;
            end
         end
         S_IDLE: begin
            if (req_valid) begin
               kind_in     = req_kind;
               key_in      = req_key;
               n_in        = n_cur;
               mod_word_in = MOD_WORD_W'(req_key);
               mod_rem_in  = '0;
               mod_cnt_in  = '0;
               if (req_kind == KIND_INSERT || req_kind == KIND_SEARCH ||
                   req_kind == KIND_REMOVE) begin
                  state_in = S_HASH;
               end else begin
                  res_status_in = STAT_ABSENT;
                  res_slot_in   = '0;
                  state_in      = S_FINISH;
               end
            end
         end
         S_HASH: begin
            mod_rem_in  = step_rem;
            mod_word_in = mod_word_ff << MOD_STEP;
            mod_cnt_in  = mod_cnt_ff + MOD_CNT_W'(1);
            if (mod_cnt_ff == MOD_CNT_W'(MOD_ITERS - 1)) begin
               s_in     = IDX_W'(step_rem);
               probe_in = '0;
               state_in = S_PROBE_RD;
            end
         end
         S_PROBE_RD: begin
            ram_raddr = s_ff;
            state_in  = S_CHECK;
         end
         S_CHECK: begin
            ram_raddr = nxt_s;
            if (kind_ff == KIND_INSERT) begin
               if (!e_valid) begin
                  ram_we        = 1'b1;
                  ram_wdata     = {1'b1, key_ff};
                  res_status_in = STAT_OK;
                  res_slot_in   = s_ff;
                  state_in      = S_FINISH;
               end else if (last_probe) begin
                  res_status_in = STAT_FULL;
                  res_slot_in   = '0;
                  state_in      = S_FINISH;
               end else begin
                  s_in     = nxt_s;
                  probe_in = probe_ff + SIZE_W'(1);
               end
            end else begin
               if (!e_valid) begin
                  res_status_in = STAT_ABSENT;
                  res_slot_in   = '0;
                  state_in      = S_FINISH;
               end else if (e_key == key_ff) begin
                  res_status_in = STAT_OK;
                  res_slot_in   = s_ff;
                  if (kind_ff == KIND_REMOVE) begin
                     // free the slot, then walk the cluster behind it
                     ram_we    = 1'b1;
                     ram_wdata = {1'b0, key_ff};
                     hole_in   = s_ff;
                     j_in      = s_ff;
                     probe_in  = '0;
                     state_in  = S_SH_READ;
                  end else begin
                     state_in = S_FINISH;
                  end
               end else if (last_probe) begin
                  res_status_in = STAT_ABSENT;
                  res_slot_in   = '0;
                  state_in      = S_FINISH;
               end else begin
                  s_in     = nxt_s;
                  probe_in = probe_ff + SIZE_W'(1);
               end
            end
         end
         S_SH_READ: begin
            ram_raddr = nxt_j;
            if (probe_ff == n_ff) begin
               state_in = S_FINISH;
            end else begin
               j_in     = nxt_j;
               probe_in = probe_ff + SIZE_W'(1);
               state_in = S_SH_DATA;
            end
         end
         S_SH_DATA: begin
            if (!e_valid) begin
               state_in = S_FINISH;
            end else begin
               jkey_in     = e_key;
               mod_word_in = MOD_WORD_W'(e_key);
               mod_rem_in  = '0;
               mod_cnt_in  = '0;
               state_in    = S_SH_HASH;
            end
         end
         S_SH_HASH: begin
            mod_rem_in  = step_rem;
            mod_word_in = mod_word_ff << MOD_STEP;
            mod_cnt_in  = mod_cnt_ff + MOD_CNT_W'(1);
            if (mod_cnt_ff == MOD_CNT_W'(MOD_ITERS - 1)) begin
               state_in = S_SH_TEST;
            end
         end
         S_SH_TEST: begin
            state_in = movable ? S_MOVE_A : S_SH_READ;
         end
         S_MOVE_A: begin
            ram_we    = 1'b1;
            ram_waddr = hole_ff;
            ram_wdata = {1'b1, jkey_ff};
            state_in  = S_MOVE_B;
         end
         S_MOVE_B: begin
            ram_we    = 1'b1;
            ram_waddr = j_ff;
            ram_wdata = {1'b0, jkey_ff};
            hole_in   = j_ff;
            state_in  = S_SH_READ;
         end
         S_FINISH: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_valid_in  = 1'b1;
               rsp_status_in = res_status_ff;
               rsp_slot_in   = SLOT_W'(res_slot_ff);
               state_in      = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_CLEAR;
         clr_ff        <= '0;
         rsp_valid_ff  <= 1'b0;
         table_size_ff <= SIZE_RESET;
      end else begin
         state_ff      <= state_in;
         clr_ff        <= clr_in;
         rsp_valid_ff  <= rsp_valid_in;
         table_size_ff <= table_size_in;
      end
   end

   always_ff @(posedge clock) begin
      kind_ff       <= kind_in;
      key_ff        <= key_in;
      jkey_ff       <= jkey_in;
      n_ff          <= n_in;
      mod_word_ff   <= mod_word_in;
      mod_rem_ff    <= mod_rem_in;
      mod_cnt_ff    <= mod_cnt_in;
      s_ff          <= s_in;
      hole_ff       <= hole_in;
      j_ff          <= j_in;
      probe_ff      <= probe_in;
      res_status_ff <= res_status_in;
      res_slot_ff   <= res_slot_in;
      rsp_status_ff <= rsp_status_in;
      rsp_slot_ff   <= rsp_slot_in;
   end

   assign rsp_valid  = rsp_valid_ff;
   assign rsp_status = rsp_status_ff;
   assign rsp_slot   = rsp_slot_ff;

   a_accept_leaves_idle: assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall) |=> (state_ff != S_IDLE))
      else $error("accepted transfer did not start an operation");

   a_probe_bound: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_CHECK) |-> (probe_ff < n_ff))
      else $error("probe count ran past the active size");

   a_miss_slot_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_status_ff != STAT_OK) |-> (rsp_slot_ff == '0))
      else $error("non-ok response carries a nonzero slot");

   a_hole_not_probe: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_SH_TEST) |-> (hole_ff != j_ff))
      else $error("backward shift tested the hole itself");

endmodule
